// ----- rtl/core/buffer_slot_pool_manager_top_defines.svh -----
`ifndef BUFFER_SLOT_POOL_MANAGER_TOP_DEFINES_SVH
`define BUFFER_SLOT_POOL_MANAGER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define BSPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buffer slot pool check failed");

// next-cycle implication, checked while out of reset
`define BSPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buffer slot pool check failed");

`endif

// ----- rtl/core/bspm_pkg.sv -----
package bspm_pkg;

   localparam int MAX_SLOTS       = 16;
   localparam int SLOT_BITS       = 4;
   localparam int CNT_BITS        = 5;
   localparam int BYTE_COUNT_BITS = 32;
   localparam int CSR_IDX_BITS    = 2;
   localparam int CSR_DATA_BITS   = 32;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOTS_IN_USE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_LOCKED   = 2'd2;

   // request opcodes
   localparam logic [3:0] OP_ACQ_FILL     = 4'd0;
   localparam logic [3:0] OP_PUBLISH      = 4'd1;
   localparam logic [3:0] OP_ACQ_READY    = 4'd2;
   localparam logic [3:0] OP_MARK_FLIGHT  = 4'd3;
   localparam logic [3:0] OP_CONSUME      = 4'd4;
   localparam logic [3:0] OP_REL_FILL     = 4'd5;
   localparam logic [3:0] OP_REL_READY    = 4'd6;
   localparam logic [3:0] OP_XFER_DONE    = 4'd7;
   localparam logic [3:0] OP_RECLAIM      = 4'd8;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NONE       = 3'd1;
   localparam logic [2:0] ST_STATE      = 3'd2;
   localparam logic [2:0] ST_CAPACITY   = 3'd3;
   localparam logic [2:0] ST_NOT_LOCKED = 3'd4;
   localparam logic [2:0] ST_BAD_SLOT   = 3'd5;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_FILLING  = 2'd1,
      PH_READY    = 2'd2,
      PH_INFLIGHT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [3:0]                 opcode;
      logic [SLOT_BITS-1:0]       slot_number;
      logic [BYTE_COUNT_BITS-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic [SLOT_BITS-1:0]       granted_slot;
      logic [BYTE_COUNT_BITS-1:0] payload_bytes;
      logic [CNT_BITS-1:0]        reclaimed_count;
   } rsp_type;

endpackage

// ----- rtl/core/buffer_slot_pool_manager_top.sv -----
// Buffer slot pool manager. A request is taken when start is high and busy is
// low; exactly one result follows as a one-cycle rsp_valid pulse that cannot be
// stalled, so the receiver must take it in that cycle. A successful acquire ready
// reads the ready queue, then the payload memory. Reclaim and acquire fill first
// scan the active slots, one slot per cycle, and push returned slots through the
// single write port of the free queue memory; acquire fill then takes the free
// queue head when a slot is free. Busy drops in the cycle the result is shown,
// so the next request can be accepted at the edge that takes the result.
// Configuration writes re-initialise the whole pool and are only allowed while
// busy is low and no result is pending.
module buffer_slot_pool_manager_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  bspm_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   output bspm_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_write_en,
   input  logic [bspm_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [bspm_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_DISPATCH   = 7'b0000010,
      S_SCAN       = 7'b0000100,
      S_FREE_RD    = 7'b0001000,
      S_FREE_WAIT  = 7'b0010000,
      S_READY_WAIT = 7'b0100000,
      S_PAY_WAIT   = 7'b1000000
   } state_type;

   localparam int SB = bspm_pkg::SLOT_BITS;
   localparam int CB = bspm_pkg::CNT_BITS;
   localparam int BB = bspm_pkg::BYTE_COUNT_BITS;
   localparam int NS = bspm_pkg::MAX_SLOTS;

   function automatic logic [CB-1:0] active_count(input logic [CB-1:0] slots);
      logic [CB-1:0] n;
      if (slots == '0) begin
         n = CB'(1);
      end else if (slots > CB'(NS)) begin
         n = CB'(NS);
      end else begin
         n = slots;
      end
      return n;
   endfunction

   state_type              state_ff, state_in;
   logic [CB-1:0]          slots_ff, slots_in;
   logic [31:0]            capacity_ff, capacity_in;
   logic                   locked_ff, locked_in;
   bspm_pkg::phase_type    phase_ff [NS];
   bspm_pkg::phase_type    phase_in [NS];
   logic [NS-1:0]          leased_ff, leased_in;
   logic [NS-1:0]          done_ff, done_in;
   logic [NS-1:0]          free_wr_ff, free_wr_in;
   logic [SB-1:0]          free_head_ff, free_head_in;
   logic [CB-1:0]          free_cnt_ff, free_cnt_in;
   logic [SB-1:0]          ready_head_ff, ready_head_in;
   logic [CB-1:0]          ready_cnt_ff, ready_cnt_in;
   logic [3:0]             op_ff, op_in;
   logic [SB-1:0]          slot_ff, slot_in;
   logic [BB-1:0]          bytes_ff, bytes_in;
   logic [SB-1:0]          scan_ff, scan_in;
   logic [CB-1:0]          reclaim_ff, reclaim_in;
   logic                   free_sel_ff, free_sel_in;
   bspm_pkg::rsp_type      resp_ff, resp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [CB-1:0]          n_active;
   logic [SB-1:0]          free_tail;
   logic [SB-1:0]          ready_tail;
   logic [SB-1:0]          free_pick;
   logic                   needs_slot;
   logic                   bad_slot;

   // memory ports
   logic                   free_we;
   logic [SB-1:0]          free_waddr, free_raddr, free_q;
   logic [SB-1:0]          free_wdata;
   logic                   ready_we;
   logic [SB-1:0]          ready_waddr, ready_raddr, ready_q;
   logic [SB-1:0]          ready_wdata;
   logic                   pay_we;
   logic [SB-1:0]          pay_waddr, pay_raddr;
   logic [BB-1:0]          pay_wdata, pay_q;

   bspm_ram #(.WIDTH(SB), .DEPTH(NS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (free_wdata),
      .rd_addr (free_raddr),
      .rd_data (free_q)
   );

   bspm_ram #(.WIDTH(SB), .DEPTH(NS)) u_ready_ram (
      .clock   (clock),
      .wr_en   (ready_we),
      .wr_addr (ready_waddr),
      .wr_data (ready_wdata),
      .rd_addr (ready_raddr),
      .rd_data (ready_q)
   );

   bspm_ram #(.WIDTH(BB), .DEPTH(NS)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (pay_wdata),
      .rd_addr (pay_raddr),
      .rd_data (pay_q)
   );

   assign n_active   = active_count(slots_ff);
   assign free_tail  = SB'(free_head_ff + free_cnt_ff[SB-1:0]);
   assign ready_tail = SB'(ready_head_ff + ready_cnt_ff[SB-1:0]);
   assign free_pick  = free_sel_ff ? free_q : free_head_ff;
   assign needs_slot = (op_ff != bspm_pkg::OP_ACQ_FILL) && (op_ff != bspm_pkg::OP_ACQ_READY)
                       && (op_ff <= bspm_pkg::OP_XFER_DONE);
   assign bad_slot   = needs_slot && ({1'b0, slot_ff} >= n_active);

   // request sequencer and slot state update
   always_comb begin
      state_in      = state_ff;
      slots_in      = slots_ff;
      capacity_in   = capacity_ff;
      locked_in     = locked_ff;
      phase_in      = phase_ff;
      leased_in     = leased_ff;
      done_in       = done_ff;
      free_wr_in    = free_wr_ff;
      free_head_in  = free_head_ff;
      free_cnt_in   = free_cnt_ff;
      ready_head_in = ready_head_ff;
      ready_cnt_in  = ready_cnt_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      bytes_in      = bytes_ff;
      scan_in       = scan_ff;
      reclaim_in    = reclaim_ff;
      free_sel_in   = free_sel_ff;
      resp_in       = resp_ff;
      rsp_valid_in  = 1'b0;
      free_we       = 1'b0;
      free_waddr    = free_tail;
      free_wdata    = slot_ff;
      free_raddr    = free_head_ff;
      ready_we      = 1'b0;
      ready_waddr   = ready_tail;
      ready_wdata   = slot_ff;
      ready_raddr   = ready_head_ff;
      pay_we        = 1'b0;
      pay_waddr     = slot_ff;
      pay_wdata     = bytes_ff;
      pay_raddr     = ready_q;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.opcode;
               slot_in  = req_data.slot_number;
               bytes_in = req_data.byte_count;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            resp_in      = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (bad_slot) begin
               resp_in.status = bspm_pkg::ST_BAD_SLOT;
            end else begin
               case (op_ff)
                  bspm_pkg::OP_ACQ_FILL, bspm_pkg::OP_RECLAIM: begin
                     rsp_valid_in = 1'b0;
                     scan_in      = '0;
                     reclaim_in   = '0;
                     state_in     = S_SCAN;
                  end
                  bspm_pkg::OP_PUBLISH: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_FILLING || !leased_ff[slot_ff]) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else if (bytes_ff > capacity_ff) begin
                        resp_in.status = bspm_pkg::ST_CAPACITY;
                     end else begin
                        pay_we             = 1'b1;
                        leased_in[slot_ff] = 1'b0;
                        phase_in[slot_ff]  = bspm_pkg::PH_READY;
                        if (ready_cnt_ff < CB'(NS)) begin
                           ready_we     = 1'b1;
                           ready_cnt_in = ready_cnt_ff + CB'(1);
                        end
                     end
                  end
                  bspm_pkg::OP_ACQ_READY: begin
                     if (ready_cnt_ff == '0) begin
                        resp_in.status = bspm_pkg::ST_NONE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_READY_WAIT;
                     end
                  end
                  bspm_pkg::OP_MARK_FLIGHT: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_READY || !leased_ff[slot_ff]) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else if (!locked_ff) begin
                        resp_in.status = bspm_pkg::ST_NOT_LOCKED;
                     end else begin
                        leased_in[slot_ff] = 1'b0;
                        phase_in[slot_ff]  = bspm_pkg::PH_INFLIGHT;
                        done_in[slot_ff]   = 1'b0;
                     end
                  end
                  bspm_pkg::OP_CONSUME: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_READY || !leased_ff[slot_ff]) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else begin
                        leased_in[slot_ff] = 1'b0;
                        phase_in[slot_ff]  = bspm_pkg::PH_FREE;
                        if (free_cnt_ff < CB'(NS)) begin
                           free_we               = 1'b1;
                           free_wr_in[free_tail] = 1'b1;
                           free_cnt_in           = free_cnt_ff + CB'(1);
                        end
                     end
                  end
                  bspm_pkg::OP_REL_FILL: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_FILLING || !leased_ff[slot_ff]) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else begin
                        leased_in[slot_ff] = 1'b0;
                        phase_in[slot_ff]  = bspm_pkg::PH_FREE;
                        if (free_cnt_ff < CB'(NS)) begin
                           free_we               = 1'b1;
                           free_wr_in[free_tail] = 1'b1;
                           free_cnt_in           = free_cnt_ff + CB'(1);
                        end
                     end
                  end
                  bspm_pkg::OP_REL_READY: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_READY || !leased_ff[slot_ff]) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else begin
                        leased_in[slot_ff] = 1'b0;
                        if (ready_cnt_ff < CB'(NS)) begin
                           ready_we     = 1'b1;
                           ready_cnt_in = ready_cnt_ff + CB'(1);
                        end
                     end
                  end
                  bspm_pkg::OP_XFER_DONE: begin
                     if (phase_ff[slot_ff] != bspm_pkg::PH_INFLIGHT) begin
                        resp_in.status = bspm_pkg::ST_STATE;
                     end else begin
                        done_in[slot_ff] = 1'b1;
                     end
                  end
                  default: begin
                     resp_in.status = bspm_pkg::ST_OK;
                  end
               endcase
            end
         end

         // one slot per cycle: return finished in-flight slots to the free queue
         S_SCAN: begin
            if (phase_ff[scan_ff] == bspm_pkg::PH_INFLIGHT && done_ff[scan_ff]) begin
               phase_in[scan_ff] = bspm_pkg::PH_FREE;
               done_in[scan_ff]  = 1'b0;
               reclaim_in        = reclaim_ff + CB'(1);
               if (free_cnt_ff < CB'(NS)) begin
                  free_we               = 1'b1;
                  free_wdata            = scan_ff;
                  free_wr_in[free_tail] = 1'b1;
                  free_cnt_in           = free_cnt_ff + CB'(1);
               end
            end
            if ({1'b0, scan_ff} == n_active - CB'(1)) begin
               if (op_ff == bspm_pkg::OP_ACQ_FILL) begin
                  state_in = S_FREE_RD;
               end else begin
                  resp_in                 = '0;
                  resp_in.reclaimed_count = reclaim_in;
                  rsp_valid_in            = 1'b1;
                  state_in                = S_IDLE;
               end
            end else begin
               scan_in = scan_ff + SB'(1);
            end
         end

         // free queue head read; unwritten positions hold their own index
         S_FREE_RD: begin
            if (free_cnt_ff == '0) begin
               resp_in                 = '0;
               resp_in.status          = bspm_pkg::ST_NONE;
               resp_in.reclaimed_count = reclaim_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end else begin
               free_sel_in = free_wr_ff[free_head_ff];
               state_in    = S_FREE_WAIT;
            end
         end

         S_FREE_WAIT: begin
            phase_in[free_pick]     = bspm_pkg::PH_FILLING;
            leased_in[free_pick]    = 1'b1;
            free_head_in            = free_head_ff + SB'(1);
            free_cnt_in             = free_cnt_ff - CB'(1);
            resp_in                 = '0;
            resp_in.granted_slot    = free_pick;
            resp_in.reclaimed_count = reclaim_ff;
            rsp_valid_in            = 1'b1;
            state_in                = S_IDLE;
         end

         // ready queue head arrived: lease it and fetch its byte count
         S_READY_WAIT: begin
            leased_in[ready_q]   = 1'b1;
            ready_head_in        = ready_head_ff + SB'(1);
            ready_cnt_in         = ready_cnt_ff - CB'(1);
            resp_in              = '0;
            resp_in.granted_slot = ready_q;
            state_in             = S_PAY_WAIT;
         end

         S_PAY_WAIT: begin
            resp_in.payload_bytes = pay_q;
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a write to a defined register re-initialises the pool
      if (csr_write_en && csr_index <= bspm_pkg::CSR_PAGE_LOCKED) begin
         case (csr_index)
            bspm_pkg::CSR_SLOTS_IN_USE: slots_in    = csr_write_data[CB-1:0];
            bspm_pkg::CSR_CAPACITY:     capacity_in = csr_write_data[31:0];
            default:                    locked_in   = csr_write_data[0];
         endcase
         for (int i = 0; i < NS; i++) begin
            phase_in[i] = bspm_pkg::PH_FREE;
         end
         leased_in     = '0;
         done_in       = '0;
         free_wr_in    = '0;
         free_head_in  = '0;
         free_cnt_in   = active_count(slots_in);
         ready_head_in = '0;
         ready_cnt_in  = '0;
         state_in      = S_IDLE;
      end
   end

   // control and slot flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slots_ff      <= CB'(NS);
         capacity_ff   <= 32'd65536;
         locked_ff     <= 1'b1;
         for (int i = 0; i < NS; i++) begin
            phase_ff[i] <= bspm_pkg::PH_FREE;
         end
         leased_ff     <= '0;
         done_ff       <= '0;
         free_wr_ff    <= '0;
         free_head_ff  <= '0;
         free_cnt_ff   <= CB'(NS);
         ready_head_ff <= '0;
         ready_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_ff      <= slots_in;
         capacity_ff   <= capacity_in;
         locked_ff     <= locked_in;
         phase_ff      <= phase_in;
         leased_ff     <= leased_in;
         done_ff       <= done_in;
         free_wr_ff    <= free_wr_in;
         free_head_ff  <= free_head_in;
         free_cnt_ff   <= free_cnt_in;
         ready_head_ff <= ready_head_in;
         ready_cnt_ff  <= ready_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request and result payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      bytes_ff    <= bytes_in;
      scan_ff     <= scan_in;
      reclaim_ff  <= reclaim_in;
      free_sel_ff <= free_sel_in;
      resp_ff     <= resp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = resp_ff;

endmodule

// ----- rtl/core/bspm_ram.sv -----
module bspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bspm_checker.sv -----
`include "buffer_slot_pool_manager_top_defines.svh"

module bspm_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input bspm_pkg::rsp_type rsp_data
);

   // an accepted request makes the block busy
   `BSPM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a result only closes a request that was in progress
   `BSPM_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

   // status code stays within the defined set
   `BSPM_ASSERT_NOW(a_status_range, clock, reset, rsp_valid,
      rsp_data.status <= bspm_pkg::ST_BAD_SLOT)

   // failed requests hand out nothing
   `BSPM_ASSERT_NOW(a_fail_no_grant, clock, reset,
      rsp_valid && rsp_data.status != bspm_pkg::ST_OK,
      rsp_data.granted_slot == '0 && rsp_data.payload_bytes == '0)

endmodule

bind buffer_slot_pool_manager_top bspm_checker u_bspm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- tb/buffer_slot_pool_manager_top_tb.sv -----
module buffer_slot_pool_manager_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bspm_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   buffer_slot_pool_manager_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // pool shadow state
   int unsigned n_slots;
   logic [31:0] capacity;
   logic        lock_mode;
   phase_type   phase_q[MAX_SLOTS];
   logic        leased_q[MAX_SLOTS];
   logic [31:0] bytes_q[MAX_SLOTS];
   logic        done_q[MAX_SLOTS];
   int unsigned free_list[$];
   int unsigned ready_list[$];

   rsp_type     pending_rsp[$];
   int          err_count;
   int          quiet_cycles;
   int          send_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rebuild pool as after reset or a register write
   function automatic void pool_clear();
      free_list.delete();
      ready_list.delete();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         phase_q[i] = PH_FREE;
         leased_q[i] = 1'b0;
         bytes_q[i] = '0;
         done_q[i] = 1'b0;
      end
      for (int i = 0; i < n_slots; i++) free_list.push_back(i);
   endfunction

   function automatic void shadow_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      if (idx == CSR_SLOTS_IN_USE) begin
         n_slots = val[4:0];
         if (n_slots == 0) n_slots = 1;
         if (n_slots > MAX_SLOTS) n_slots = MAX_SLOTS;
      end else if (idx == CSR_CAPACITY) capacity = val;
      else if (idx == CSR_PAGE_LOCKED) lock_mode = val[0];
      else return;
      pool_clear();
   endfunction

   function automatic logic [4:0] sweep_finished();
      logic [4:0] got;
      got = '0;
      for (int i = 0; i < n_slots; i++) begin
         if (phase_q[i] == PH_INFLIGHT && done_q[i]) begin
            phase_q[i] = PH_FREE;
            bytes_q[i] = '0;
            done_q[i] = 1'b0;
            free_list.push_back(i);
            got++;
         end
      end
      return got;
   endfunction

   function automatic rsp_type pool_predict(req_type r);
      rsp_type o;
      int unsigned s;
      int unsigned k;
      logic ready_leased;
      o = '0;
      s = r.slot_number;
      ready_leased = (phase_q[s] == PH_READY) && leased_q[s];
      if (r.opcode != OP_ACQ_FILL && r.opcode != OP_ACQ_READY && r.opcode <= OP_XFER_DONE
          && s >= n_slots) begin
         o.status = ST_BAD_SLOT;
         return o;
      end
      case (r.opcode)
         OP_ACQ_FILL: begin
            o.reclaimed_count = sweep_finished();
            if (free_list.size() == 0) o.status = ST_NONE;
            else begin
               k = free_list.pop_front();
               phase_q[k] = PH_FILLING;
               leased_q[k] = 1'b1;
               bytes_q[k] = '0;
               o.granted_slot = SLOT_BITS'(k);
            end
         end
         OP_PUBLISH: begin
            if (phase_q[s] != PH_FILLING || !leased_q[s]) o.status = ST_STATE;
            else if (r.byte_count > capacity) o.status = ST_CAPACITY;
            else begin
               bytes_q[s] = r.byte_count;
               leased_q[s] = 1'b0;
               phase_q[s] = PH_READY;
               ready_list.push_back(s);
            end
         end
         OP_ACQ_READY: begin
            if (ready_list.size() == 0) o.status = ST_NONE;
            else begin
               k = ready_list.pop_front();
               leased_q[k] = 1'b1;
               o.granted_slot = SLOT_BITS'(k);
               o.payload_bytes = bytes_q[k];
            end
         end
         OP_MARK_FLIGHT: begin
            if (!ready_leased) o.status = ST_STATE;
            else if (!lock_mode) o.status = ST_NOT_LOCKED;
            else begin
               leased_q[s] = 1'b0;
               phase_q[s] = PH_INFLIGHT;
               done_q[s] = 1'b0;
            end
         end
         OP_CONSUME: begin
            if (!ready_leased) o.status = ST_STATE;
            else begin
               bytes_q[s] = '0;
               leased_q[s] = 1'b0;
               phase_q[s] = PH_FREE;
               free_list.push_back(s);
            end
         end
         OP_REL_FILL: begin
            if (phase_q[s] != PH_FILLING || !leased_q[s]) o.status = ST_STATE;
            else begin
               bytes_q[s] = '0;
               leased_q[s] = 1'b0;
               phase_q[s] = PH_FREE;
               free_list.push_back(s);
            end
         end
         OP_REL_READY: begin
            if (!ready_leased) o.status = ST_STATE;
            else begin
               leased_q[s] = 1'b0;
               ready_list.push_back(s);
            end
         end
         OP_XFER_DONE: begin
            if (phase_q[s] != PH_INFLIGHT) o.status = ST_STATE;
            else done_q[s] = 1'b1;
         end
         OP_RECLAIM: o.reclaimed_count = sweep_finished();
         default: ;
      endcase
      return o;
   endfunction

   // one register write while the pool is idle, then write enable is dropped before returning
   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow_csr(idx, val);
      @(posedge clock);
   endtask

   // request transfer; start stays high until the next idle cycle or drain
   // the check value, when given, is compared with the prediction
   task automatic send_req(req_type r, logic use_fixed = 1'b0, rsp_type fixed = '0);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = pool_predict(r);
      if (use_fixed && p !== fixed) begin
         $display("%0t predictor disagrees with table: exp %h got %h", $time, fixed, p);
         err_count++;
      end
      pending_rsp.push_back(p);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: got %h", $time, rsp_data);
            err_count++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status)
               $display("%0t status: exp %0d got %0d", $time, e.status, rsp_data.status);
            if (rsp_data.granted_slot !== e.granted_slot)
               $display("%0t granted_slot: exp %0d got %0d", $time, e.granted_slot,
                        rsp_data.granted_slot);
            if (rsp_data.payload_bytes !== e.payload_bytes)
               $display("%0t payload_bytes: exp %h got %h", $time, e.payload_bytes,
                        rsp_data.payload_bytes);
            if (rsp_data.reclaimed_count !== e.reclaimed_count)
               $display("%0t reclaimed_count: exp %0d got %0d", $time, e.reclaimed_count,
                        rsp_data.reclaimed_count);
            if (rsp_data !== e) err_count++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type mk(logic [3:0] op, logic [3:0] s, logic [31:0] b = '0);
      req_type r;
      r.opcode = op;
      r.slot_number = s;
      r.byte_count = b;
      return r;
   endfunction

   function automatic rsp_type rs(logic [2:0] st, logic [3:0] g = '0,
                                  logic [31:0] p = '0, logic [4:0] c = '0);
      rsp_type o;
      o.status = st;
      o.granted_slot = g;
      o.payload_bytes = p;
      o.reclaimed_count = c;
      return o;
   endfunction

   // random request, mostly aimed at live slots
   function automatic req_type rand_req();
      req_type r;
      int unsigned sel;
      int unsigned s;
      s = $urandom_range(n_slots - 1);
      sel = $urandom_range(99);
      for (int i = 0; i < MAX_SLOTS; i++) begin
         int unsigned j;
         j = (s + i) % n_slots;
         if (sel < 60 && phase_q[j] != PH_FREE) begin
            s = j;
            break;
         end
      end
      if (sel >= 95) s = $urandom_range(15);
      r.slot_number = SLOT_BITS'(s);
      if ($urandom_range(99) < 3) r.opcode = 4'($urandom_range(15));
      else begin
         case (phase_q[s])
            PH_FILLING: r.opcode = $urandom_range(3) == 0 ? OP_REL_FILL : OP_PUBLISH;
            PH_READY: r.opcode = leased_q[s] ?
               (($urandom_range(2) == 0) ? OP_MARK_FLIGHT :
                ($urandom_range(1) ? OP_CONSUME : OP_REL_READY)) : OP_ACQ_READY;
            PH_INFLIGHT: r.opcode = $urandom_range(3) == 0 ? OP_RECLAIM : OP_XFER_DONE;
            default: r.opcode = $urandom_range(2) == 0 ? OP_ACQ_READY : OP_ACQ_FILL;
         endcase
         if ($urandom_range(9) == 0) r.opcode = 4'($urandom_range(OP_RECLAIM));
      end
      case ($urandom_range(3))
         0: r.byte_count = $urandom();
         1: r.byte_count = capacity - $urandom_range(1);
         2: r.byte_count = capacity + 1;
         default: r.byte_count = $urandom_range(capacity);
      endcase
      return r;
   endfunction

   typedef struct {
      req_type req;
      logic    fixed;
      rsp_type rsp;
   } step_row;

   step_row steps[$];

   initial begin
      err_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 19;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      n_slots = 16;
      capacity = 32'd65536;
      lock_mode = 1'b1;
      pool_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: reset state, extremes, error paths
      steps = '{
         '{mk(OP_ACQ_READY, 0), 1, rs(ST_NONE)},
         '{mk(OP_PUBLISH, 3), 1, rs(ST_STATE)},
         '{mk(OP_XFER_DONE, 15), 1, rs(ST_STATE)},
         '{mk(OP_ACQ_FILL, 9), 1, rs(ST_OK, 0)},
         '{mk(OP_ACQ_FILL, 0), 1, rs(ST_OK, 1)},
         '{mk(OP_PUBLISH, 0, 32'd65537), 1, rs(ST_CAPACITY)},
         '{mk(OP_PUBLISH, 0, 32'd65536), 1, rs(ST_OK)},
         '{mk(OP_PUBLISH, 1, 32'd0), 1, rs(ST_OK)},
         '{mk(OP_ACQ_READY, 0), 1, rs(ST_OK, 0, 32'd65536)},
         '{mk(OP_REL_READY, 0), 0, rs(ST_OK)},
         '{mk(OP_ACQ_READY, 0), 0, rs(ST_OK)},
         '{mk(OP_MARK_FLIGHT, 1), 0, rs(ST_OK)},
         '{mk(OP_ACQ_READY, 0), 0, rs(ST_OK)},
         '{mk(OP_CONSUME, 0), 0, rs(ST_OK)},
         '{mk(OP_XFER_DONE, 1), 0, rs(ST_OK)},
         '{mk(OP_XFER_DONE, 1), 0, rs(ST_OK)},
         '{mk(OP_RECLAIM, 0), 0, rs(ST_OK)},
         '{mk(4'd15, 4'd15, 32'hFFFF_FFFF), 1, rs(ST_OK)},
         '{mk(OP_ACQ_FILL, 0), 0, rs(ST_OK)},
         '{mk(OP_REL_FILL, 2), 0, rs(ST_OK)},
         '{mk(OP_REL_FILL, 2), 1, rs(ST_STATE)}
      };
      foreach (steps[i]) send_req(steps[i].req, steps[i].fixed, steps[i].rsp);
      drain();

      // small pool, not page locked
      csr_write(CSR_SLOTS_IN_USE, 32'd1);
      csr_write(CSR_PAGE_LOCKED, 32'd0);
      csr_write(CSR_CAPACITY, 32'd1);
      send_req(mk(OP_PUBLISH, 4'd1), 1'b1, rs(ST_BAD_SLOT));
      send_req(mk(OP_ACQ_FILL, 0), 1'b1, rs(ST_OK));
      send_req(mk(OP_ACQ_FILL, 0), 1'b1, rs(ST_NONE));
      send_req(mk(OP_PUBLISH, 0, 32'd1), 1'b1, rs(ST_OK));
      send_req(mk(OP_ACQ_READY, 0), 1'b1, rs(ST_OK, 0, 32'd1));
      send_req(mk(OP_MARK_FLIGHT, 0), 1'b1, rs(ST_NOT_LOCKED));
      drain();

      // random phases across settings and idling profiles
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: csr_write(CSR_SLOTS_IN_USE, 32'd0);
            1: csr_write(CSR_SLOTS_IN_USE, 32'd31);
            default: csr_write(CSR_SLOTS_IN_USE, $urandom_range(31));
         endcase
         csr_write(CSR_CAPACITY, ph == 1 ? 32'hFFFF_FFFF : $urandom_range(ph == 0 ? 1 : 5000));
         csr_write(CSR_PAGE_LOCKED, 32'(ph % 3 != 2));
         send_idle_pct = ph < 2 ? 19 : (ph < 4 ? 56 : 0);
         repeat (85) send_req(rand_req());
         drain();
      end

      if (err_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
